@@ rtl/rtrl_pkg.sv @@
// shared constants and types of the recurrent relu neuron
package rtrl_pkg;

   localparam int FAN_IN     = 16;
   localparam int RESULT_CAP = 16;
   localparam int DATA_W     = 16;
   localparam int VAL_W      = 15;
   localparam int SIDX_W     = 4;
   localparam int SUM_W      = 40;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int CNT_W      = $clog2(FAN_IN + 1);
   localparam int IDX_W      = (FAN_IN > 1) ? $clog2(FAN_IN) : 1;
   localparam int CAP_W      = $clog2(RESULT_CAP + 1);
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_FIRE,
      ST_MUL1,
      ST_UPD,
      ST_MUL2,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic in_we;
      logic tr_we;
   } cell_ctrl_type;

endpackage

@@ rtl/rtrl_if.sv @@
// request and response channel interfaces of the recurrent relu neuron
interface rtrl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] input_value;
   logic signed [15:0] syn_weight;
   logic               is_self;
   logic signed [15:0] out_weight;
   logic               last_synapse;

   modport source (
      output valid, input_value, syn_weight, is_self, out_weight, last_synapse,
      input  ready
   );
   modport sink (
      input  valid, input_value, syn_weight, is_self, out_weight, last_synapse,
      output ready
   );
endinterface

interface rtrl_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         synapse_index;
   logic signed [15:0] gradient;
   logic [14:0]        neuron_value;
   logic               last_result;

   modport source (
      output valid, synapse_index, gradient, neuron_value, last_result,
      input  ready
   );
   modport sink (
      input  valid, synapse_index, gradient, neuron_value, last_result,
      output ready
   );
endinterface

@@ rtl/rtrl_cell.sv @@
// one synapse cell: stored input and trace, shifted toward its neighbor
module rtrl_cell
   import rtrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] load_value,
   input  logic signed [DATA_W-1:0] trace_value,
   input  logic signed [DATA_W-1:0] nb_input,
   input  logic signed [DATA_W-1:0] nb_trace,
   output logic signed [DATA_W-1:0] input_q,
   output logic signed [DATA_W-1:0] trace_q
);

   logic signed [DATA_W-1:0] input_ff, input_in;
   logic signed [DATA_W-1:0] trace_ff, trace_in;

   always_comb begin
      input_in = input_ff;
      if (ctrl.in_we) begin
         input_in = load_value;
      end else if (ctrl.shift) begin
         input_in = nb_input;
      end
   end

   always_comb begin
      trace_in = trace_ff;
      if (ctrl.clear) begin
         trace_in = '0;
      end else if (ctrl.tr_we) begin
         trace_in = trace_value;
      end else if (ctrl.shift) begin
         trace_in = nb_trace;
      end
   end

   always_ff @(posedge clock) begin
      input_ff <= input_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_ff <= '0;
      end else begin
         trace_ff <= trace_in;
      end
   end

   assign input_q = input_ff;
   assign trace_q = trace_ff;

endmodule

@@ rtl/rtrl_cell_row.sv @@
// ring of synapse cells; cell zero is the head that the update logic sees
module rtrl_cell_row
   import rtrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]         load_index,
   input  logic signed [DATA_W-1:0] load_value,
   input  logic signed [DATA_W-1:0] trace_value,
   output logic signed [DATA_W-1:0] head_input,
   output logic signed [DATA_W-1:0] head_trace
);

   logic signed [DATA_W-1:0] in_q [FAN_IN];
   logic signed [DATA_W-1:0] tr_q [FAN_IN];

   for (genvar k = 0; k < FAN_IN; k++) begin : g_cell
      cell_ctrl_type cell_ctrl;

      always_comb begin
         cell_ctrl       = ctrl;
         cell_ctrl.in_we = ctrl.in_we && (load_index == IDX_W'(k));
         cell_ctrl.tr_we = ctrl.tr_we && (k == 0);
      end

      rtrl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .load_value  (load_value),
         .trace_value (trace_value),
         .nb_input    (in_q[(k + 1) % FAN_IN]),
         .nb_trace    (tr_q[(k + 1) % FAN_IN]),
         .input_q     (in_q[k]),
         .trace_q     (tr_q[k])
      );
   end

   assign head_input = in_q[0];
   assign head_trace = tr_q[0];

endmodule

@@ rtl/rtrl_recurrent_relu_neuron.sv @@
// top level of the recurrent relu neuron with rtrl traces
//
// In each synapse transaction the shared 16x16 multiplier forms input times
// weight, then the 40-bit saturating accumulator adds it. The transaction
// marked last fires the neuron: the relu value is computed, then the ring of
// FAN_IN cells rotates once past the head. Each live synapse goes through a
// multiply, a trace update, a multiply by the outgoing weight and a load of
// the response register at the head, plus any wait on rsp.ready; each unused
// cell is simply rotated past, and a closing step follows. Requests are
// refused during the firing pass. The response register lets the next step
// start while the final gradient still waits. Traces reset to zero at once;
// writing learning_enable as 0 clears them in the same cycle.
module rtrl_recurrent_relu_neuron
   import rtrl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   rtrl_req_if.sink req,
   rtrl_rsp_if.source rsp,
   input  logic     csr_we,
   input  logic     csr_wdata
);

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [24:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 25'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -25'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] self_w_ff, self_w_in;
   logic [IDX_W-1:0]         self_pos_ff, self_pos_in;
   logic                     self_seen_ff, self_seen_in;
   logic signed [DATA_W-1:0] wo_ff, wo_in;
   logic                     last_ff, last_in;
   logic                     inrange_ff, inrange_in;
   logic [VAL_W-1:0]         prev_ff, prev_in;
   logic [VAL_W-1:0]         old_ff, old_in;
   logic [VAL_W-1:0]         nv_ff, nv_in;
   logic                     learn_ff, learn_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SIDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic signed [DATA_W-1:0] rsp_grad_ff, rsp_grad_in;
   logic [VAL_W-1:0]         rsp_val_ff, rsp_val_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     in_range;
   logic                     elem_live;
   logic                     elem_emit;
   logic                     elem_last;
   logic                     idx_end;
   logic                     out_free;
   logic                     rsp_load;
   logic                     prod_load;
   logic                     rotate;
   cell_ctrl_type            cell_ctrl;

   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [23:0]       prod_sh;
   logic signed [SUM_W:0]    acc_wide;
   logic signed [SUM_W-1:0]  acc_sat;
   logic signed [SUM_W-1:0]  sum_sh;
   logic [VAL_W-1:0]         nv_calc;
   logic signed [16:0]       src;
   logic signed [24:0]       tr_sum;
   logic signed [DATA_W-1:0] tr_new;
   logic [CMP_W-1:0]         emit_n;
   logic signed [DATA_W-1:0] head_input, head_trace;

   rtrl_cell_row u_row (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cell_ctrl),
      .load_index  (cnt_ff[IDX_W-1:0]),
      .load_value  (req.input_value),
      .trace_value (tr_new),
      .head_input  (head_input),
      .head_trace  (head_trace)
   );

   // status terms
   assign accept    = req.valid && req.ready;
   assign in_range  = cnt_ff < CNT_W'(FAN_IN);
   assign elem_live = idx_ff < cnt_ff;
   assign emit_n    = (CMP_W'(cnt_ff) < CMP_W'(RESULT_CAP)) ? CMP_W'(cnt_ff)
                                                           : CMP_W'(RESULT_CAP);
   assign elem_emit = elem_live && (CMP_W'(idx_ff) < CMP_W'(RESULT_CAP));
   assign elem_last = (CMP_W'(idx_ff) + CMP_W'(1)) == emit_n;
   assign idx_end   = idx_ff == CNT_W'(FAN_IN - 1);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = last_ff ? ST_FIRE : ST_IDLE;
         end
         ST_FIRE: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            if (elem_live) begin
               state_in = ST_UPD;
            end else if (idx_end) begin
               state_in = ST_DONE;
            end
         end
         ST_UPD: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!elem_emit || out_free) begin
               state_in = idx_end ? ST_DONE : ST_MUL1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req.ready = 1'b0;
      rotate    = 1'b0;
      rsp_load  = 1'b0;
      prod_load = 1'b0;
      cell_ctrl = '0;
      mul_a     = head_trace;
      mul_b     = wo_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            mul_a     = req.input_value;
            mul_b     = req.syn_weight;
            prod_load = accept;
            cell_ctrl.in_we = accept && in_range;
         end
         ST_MUL1: begin
            mul_a     = self_w_ff;
            mul_b     = head_trace;
            prod_load = elem_live;
            rotate    = !elem_live;
         end
         ST_UPD: begin
            cell_ctrl.tr_we = 1'b1;
         end
         ST_MUL2: begin
            prod_load = 1'b1;
         end
         ST_EMIT: begin
            rotate   = !elem_emit || out_free;
            rsp_load = elem_emit && out_free;
         end
         default: begin
            rotate = 1'b0;
         end
      endcase
      cell_ctrl.shift = rotate;
      cell_ctrl.clear = csr_we && !csr_wdata;
   end

   // arithmetic
   assign mul_p    = mul_a * mul_b;
   assign prod_sh  = prod_ff[PROD_W-1:8];
   assign acc_wide = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(prod_ff);
   assign acc_sat  = (acc_wide[SUM_W] != acc_wide[SUM_W-1])
                     ? (acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}})
                     : acc_wide[SUM_W-1:0];
   assign sum_sh   = sum_ff >>> 8;
   assign nv_calc  = (sum_ff <= 0) ? '0
                   : (sum_sh > SUM_W'(32767)) ? {VAL_W{1'b1}}
                   : sum_sh[VAL_W-1:0];
   assign src      = (self_seen_ff && (idx_ff[IDX_W-1:0] == self_pos_ff))
                     ? $signed({2'b00, old_ff}) : 17'(head_input);
   assign tr_sum   = 25'(src) + 25'(prod_sh);
   assign tr_new   = (learn_ff && (nv_ff != '0)) ? sat16(tr_sum) : '0;

   // datapath next values
   always_comb begin
      sum_in       = sum_ff;
      prod_in      = prod_load ? mul_p : prod_ff;
      cnt_in       = cnt_ff;
      idx_in       = rotate ? idx_ff + CNT_W'(1) : idx_ff;
      self_w_in    = self_w_ff;
      self_pos_in  = self_pos_ff;
      self_seen_in = self_seen_ff;
      wo_in        = wo_ff;
      last_in      = last_ff;
      inrange_in   = inrange_ff;
      prev_in      = prev_ff;
      old_in       = old_ff;
      nv_in        = nv_ff;
      learn_in     = csr_we ? csr_wdata : learn_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wo_in      = req.out_weight;
               last_in    = req.last_synapse;
               inrange_in = in_range;
               if (in_range && req.is_self) begin
                  self_w_in    = req.syn_weight;
                  self_pos_in  = cnt_ff[IDX_W-1:0];
                  self_seen_in = 1'b1;
               end
            end
         end
         ST_ACC: begin
            if (inrange_ff) begin
               sum_in = acc_sat;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FIRE: begin
            nv_in   = nv_calc;
            old_in  = prev_ff;
            prev_in = nv_calc;
            sum_in  = '0;
            idx_in  = '0;
         end
         ST_DONE: begin
            cnt_in       = '0;
            idx_in       = '0;
            self_w_in    = '0;
            self_pos_in  = '0;
            self_seen_in = 1'b0;
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_grad_in  = rsp_grad_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = SIDX_W'(idx_ff);
         rsp_grad_in  = sat16(25'(prod_sh));
         rsp_val_in   = nv_ff;
         rsp_last_in  = elem_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         self_w_ff    <= '0;
         self_pos_ff  <= '0;
         self_seen_ff <= 1'b0;
         last_ff      <= 1'b0;
         inrange_ff   <= 1'b0;
         prev_ff      <= '0;
         learn_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         self_w_ff    <= self_w_in;
         self_pos_ff  <= self_pos_in;
         self_seen_ff <= self_seen_in;
         last_ff      <= last_in;
         inrange_ff   <= inrange_in;
         prev_ff      <= prev_in;
         learn_ff     <= learn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      wo_ff       <= wo_in;
      old_ff      <= old_in;
      nv_ff       <= nv_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_grad_ff <= rsp_grad_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.synapse_index = rsp_idx_ff;
   assign rsp.gradient      = rsp_grad_ff;
   assign rsp.neuron_value  = rsp_val_ff;
   assign rsp.last_result   = rsp_last_ff;

endmodule

@@ test/tb_rtrl_recurrent_relu_neuron.sv @@
// self-checking testbench of the recurrent relu neuron with rtrl traces
`timescale 1ns / 1ps

module tb_rtrl_recurrent_relu_neuron;
   import rtrl_pkg::*;

   localparam int  STALL_LIMIT = 2000;
   localparam int  SETTLE_CYCLES = 120;
   localparam int  NUM_ROWS = 11;
   localparam longint ACC_MAX = (64'sd1 <<< 39) - 1;
   localparam longint ACC_MIN = -ACC_MAX - 1;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] w;
      logic               self_flag;
      logic signed [15:0] wo;
      logic               last;
   } synapse_type;

   typedef struct {
      logic [3:0]         index;
      logic signed [15:0] grad;
      logic [14:0]        value;
      logic               last;
   } gradient_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] w;
      logic               self_flag;
      logic signed [15:0] wo;
      logic               last;
      bit                 typed;
      logic [14:0]        exp_value;
      logic signed [15:0] exp_grad;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   rtrl_req_if req_bus ();
   rtrl_rsp_if rsp_bus ();

   rtrl_recurrent_relu_neuron uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state of the neuron
   bit                 learn_on = 1'b1;
   logic signed [15:0] synapse_inputs [FAN_IN];
   logic signed [15:0] traces [FAN_IN];
   longint             acc_sum = 0;
   longint             prev_value = 0;
   logic signed [15:0] self_w = '0;
   int                 syn_count = 0;
   int                 self_pos = 0;
   bit                 self_seen = 1'b0;

   gradient_type gradients_due [$];
   int           err_count = 0;
   int           idle_cycles = 0;
   bit           req_burst = 1'b0;
   bit           rsp_burst = 1'b0;
   stim_row_type dir_rows [NUM_ROWS];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 31) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic signed [15:0] pick_q88();
      case ($urandom_range(0, 7))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               default: return 16'shffff;
            endcase
         end
         default: return 16'($urandom_range(0, 1535) - 768);
      endcase
   endfunction

   // accumulate one synapse and, on the last one, fire and queue the gradients
   task automatic predict_synapse(input synapse_type s);
      longint sum;
      longint nv;
      longint old_val;
      longint t;
      longint src;
      logic signed [15:0] ws;
      int emit;
      gradient_type g;
      if (syn_count < FAN_IN) begin
         sum = acc_sum + longint'(s.x) * longint'(s.w);
         if (sum > ACC_MAX) sum = ACC_MAX;
         if (sum < ACC_MIN) sum = ACC_MIN;
         acc_sum = sum;
         synapse_inputs[syn_count] = s.x;
         if (s.self_flag) begin
            self_w = s.w;
            self_pos = syn_count;
            self_seen = 1'b1;
         end
         syn_count++;
      end
      if (!s.last) return;
      nv = (acc_sum > 0) ? (acc_sum >>> 8) : 0;
      if (nv > 32767) nv = 32767;
      old_val = prev_value;
      prev_value = nv;
      ws = self_seen ? self_w : 16'sh0000;
      for (int i = 0; i < syn_count; i++) begin
         if (!learn_on || nv <= 0) begin
            t = 0;
         end else begin
            src = (self_seen && i == self_pos) ? old_val : longint'(synapse_inputs[i]);
            t = src + ((longint'(ws) * longint'(traces[i])) >>> 8);
         end
         traces[i] = clip16(t);
      end
      emit = (syn_count < RESULT_CAP) ? syn_count : RESULT_CAP;
      for (int i = 0; i < emit; i++) begin
         g.index = i[3:0];
         g.grad  = clip16((longint'(traces[i]) * longint'(s.wo)) >>> 8);
         g.value = nv[14:0];
         g.last  = (i + 1 == emit);
         gradients_due.push_back(g);
      end
      acc_sum = 0;
      syn_count = 0;
      self_w = '0;
      self_pos = 0;
      self_seen = 1'b0;
   endtask

   task automatic send_synapse(input synapse_type s, input bit typed,
                               input logic [14:0] ev, input logic signed [15:0] eg);
      int gap;
      int base;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.input_value  <= s.x;
      req_bus.syn_weight   <= s.w;
      req_bus.is_self      <= s.self_flag;
      req_bus.out_weight   <= s.wo;
      req_bus.last_synapse <= s.last;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      base = gradients_due.size();
      predict_synapse(s);
      if (typed) begin
         for (int i = base; i < gradients_due.size(); i++) begin
            gradients_due[i].value = ev;
            gradients_due[i].grad  = eg;
         end
      end
   endtask

   task automatic wait_drained();
      while (gradients_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_learning(input bit v);
      req_bus.valid <= 1'b0;
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      learn_on = v;
      if (!v) begin
         foreach (traces[i]) traces[i] = '0;
      end
   endtask

   task automatic send_random_step(output int sent);
      int len;
      synapse_type s;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(FAN_IN + 1, FAN_IN + 4)
                                        : $urandom_range(1, FAN_IN);
      for (int i = 0; i < len; i++) begin
         s.x         = pick_q88();
         s.w         = pick_q88();
         s.self_flag = ($urandom_range(0, 3) == 0);
         s.wo        = pick_q88();
         s.last      = (i == len - 1);
         send_synapse(s, 1'b0, '0, '0);
      end
      sent = len;
   endtask

   initial begin
      synapse_type s;
      int sent;
      int quota;
      bit phase_learn [4];
      int phase_items [4];
      phase_learn = '{1'b0, 1'b1, 1'b0, 1'b1};
      phase_items = '{60, 140, 60, 140};
      foreach (traces[i]) begin
         traces[i] = '0;
         synapse_inputs[i] = '0;
      end
      //           x        w        self wo       last typed value   grad
      dir_rows = '{
         '{16'sd256,    16'sd256,    1'b0, 16'sd256,    1'b1, 1'b1, 15'd256,   16'sd256},
         '{-16'sd32768, -16'sd32768, 1'b0, 16'sd32767,  1'b1, 1'b1, 15'd32767, -16'sd32768},
         '{16'sd32767,  -16'sd32768, 1'b0, 16'sd32767,  1'b1, 1'b1, 15'd0,     16'sd0},
         '{-16'sd32768, -16'sd256,   1'b0, -16'sd32768, 1'b1, 1'b1, 15'd32767, 16'sd32767},
         '{16'sd512,    16'sd128,    1'b0, 16'sd0,      1'b0, 1'b0, 15'd0,     16'sd0},
         '{16'sd100,    16'sd256,    1'b1, 16'sd0,      1'b0, 1'b0, 15'd0,     16'sd0},
         '{-16'sd256,   16'sd64,     1'b0, -16'sd256,   1'b1, 1'b0, 15'd0,     16'sd0},
         '{16'sd256,    16'sd256,    1'b1, 16'sd0,      1'b0, 1'b0, 15'd0,     16'sd0},
         '{16'sd128,    -16'sd512,   1'b1, 16'sd0,      1'b0, 1'b0, 15'd0,     16'sd0},
         '{16'sd1024,   16'sd512,    1'b0, 16'sd32767,  1'b1, 1'b0, 15'd0,     16'sd0},
         '{16'sd300,    16'sd200,    1'b1, 16'sd1000,   1'b1, 1'b0, 15'd0,     16'sd0}
      };
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_wdata            <= 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.input_value  <= '0;
      req_bus.syn_weight   <= '0;
      req_bus.is_self      <= 1'b0;
      req_bus.out_weight   <= '0;
      req_bus.last_synapse <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         s.x         = dir_rows[r].x;
         s.w         = dir_rows[r].w;
         s.self_flag = dir_rows[r].self_flag;
         s.wo        = dir_rows[r].wo;
         s.last      = dir_rows[r].last;
         send_synapse(s, dir_rows[r].typed, dir_rows[r].exp_value, dir_rows[r].exp_grad);
      end

      foreach (phase_learn[p]) begin
         write_learning(phase_learn[p]);
         quota = 0;
         while (quota < phase_items[p]) begin
            send_random_step(sent);
            quota += sent;
         end
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      if (gradients_due.size() != 0) begin
         $display("%0t: %0d gradient transactions never arrived", $time,
                  gradients_due.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // gradient sink with random back-pressure
   initial begin
      int gap;
      gradient_type exp_g;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         if (gradients_due.size() == 0) begin
            $display("%0t: unexpected gradient transaction, expected none, actual index %0d",
                     $time, rsp_bus.synapse_index);
            err_count++;
         end else begin
            exp_g = gradients_due.pop_front();
            if (rsp_bus.synapse_index !== exp_g.index) begin
               $display("%0t: synapse_index mismatch, expected %0d actual %0d", $time,
                        exp_g.index, rsp_bus.synapse_index);
               err_count++;
            end
            if (rsp_bus.gradient !== exp_g.grad) begin
               $display("%0t: gradient mismatch, expected %0d actual %0d", $time,
                        exp_g.grad, rsp_bus.gradient);
               err_count++;
            end
            if (rsp_bus.neuron_value !== exp_g.value) begin
               $display("%0t: neuron_value mismatch, expected %0d actual %0d", $time,
                        exp_g.value, rsp_bus.neuron_value);
               err_count++;
            end
            if (rsp_bus.last_result !== exp_g.last) begin
               $display("%0t: last_result mismatch, expected %0b actual %0b", $time,
                        exp_g.last, rsp_bus.last_result);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule

@@ rtrl_recurrent_relu_neuron.f @@
rtl/rtrl_pkg.sv
rtl/rtrl_if.sv
rtl/rtrl_cell.sv
rtl/rtrl_cell_row.sv
rtl/rtrl_recurrent_relu_neuron.sv
test/tb_rtrl_recurrent_relu_neuron.sv
